// ===== sv/linear_queue_with_reverse_dedup_top_macros.svh =====
`ifndef LINEAR_QUEUE_WITH_REVERSE_DEDUP_TOP_MACROS_SVH
`define LINEAR_QUEUE_WITH_REVERSE_DEDUP_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LQRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define LQRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lqrd_pkg.sv =====
package lqrd_pkg;

   localparam int FUNC_W   = 3;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FN_ENQ      = 3'd0;
   localparam logic [FUNC_W-1:0] FN_DEQ      = 3'd1;
   localparam logic [FUNC_W-1:0] FN_PEEK     = 3'd2;
   localparam logic [FUNC_W-1:0] FN_LIST_FWD = 3'd3;
   localparam logic [FUNC_W-1:0] FN_LIST_REV = 3'd4;
   localparam logic [FUNC_W-1:0] FN_REVERSE  = 3'd5;
   localparam logic [FUNC_W-1:0] FN_UNIQUE   = 3'd6;

   localparam logic [STATUS_W-1:0] RSP_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_EMPTY    = 2'd2;

   typedef enum logic [1:0] {SRC_ZERO, SRC_NONE, SRC_SLOT, SRC_PEND} out_src_type;
   typedef enum logic [1:0] {RA_HEAD, RA_TAIL, RA_CURSOR, RA_CUR_NEXT} slot_addr_type;
   typedef enum logic [1:0] {CUR_HOLD, CUR_HEAD, CUR_TAIL, CUR_STEP} cur_op_type;
   typedef enum logic [1:0] {K_HOLD, K_ZERO, K_STEP} k_op_type;
   typedef enum logic [1:0] {SR_ZERO, SR_K, SR_K_NEXT} seen_addr_type;
   typedef enum logic [1:0] {SW_NONE, SW_SLOT, SW_APPEND} seen_wr_type;

   typedef struct packed {
      logic                out_load;
      logic [STATUS_W-1:0] out_status;
      out_src_type         out_src;
      logic                out_last;
      logic                enq;
      logic                deq;
      logic                rev_done;
      logic                slot_rd;
      slot_addr_type       slot_addr;
      logic                slot_wr_tmp;
      cur_op_type          cur_op;
      k_op_type            k_op;
      logic                seen_rd;
      seen_addr_type       seen_addr;
      seen_wr_type         seen_wr;
      logic                seen_clear;
      logic                word_ld;
   } cmd_type;

   typedef struct packed {
      logic holds;
      logic full;
      logic at_end;
      logic k_at_span;
      logic k_last_seen;
      logic seen_empty;
      logic hit;
      logic out_free;
   } stat_type;

endpackage

// ===== sv/lqrd_ram.sv =====
module lqrd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lqrd_ctrl.sv =====
module lqrd_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [lqrd_pkg::FUNC_W-1:0]       req_func,
   input  lqrd_pkg::stat_type                stat,
   output logic                              req_stall,
   output lqrd_pkg::cmd_type                 cmd
);

   import lqrd_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SINGLE   = 4'd1;
   localparam logic [3:0] ST_LIST     = 4'd2;
   localparam logic [3:0] ST_R1_RD    = 4'd3;
   localparam logic [3:0] ST_R1_WR    = 4'd4;
   localparam logic [3:0] ST_R2_RD    = 4'd5;
   localparam logic [3:0] ST_R2_WR    = 4'd6;
   localparam logic [3:0] ST_REV_DONE = 4'd7;
   localparam logic [3:0] ST_U_WORD   = 4'd8;
   localparam logic [3:0] ST_U_CMP    = 4'd9;
   localparam logic [3:0] ST_U_EMIT   = 4'd10;
   localparam logic [3:0] ST_U_FINAL  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       accept;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = !((state_ff == ST_IDLE) && stat.out_free);
      accept    = req_valid && !req_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FN_ENQ) begin
                  cmd.out_load = 1'b1;
                  cmd.out_last = 1'b1;
                  if (stat.holds && stat.full) begin
                     cmd.out_status = RSP_OVERFLOW;
                     cmd.out_src    = SRC_NONE;
                  end else begin
                     cmd.enq        = 1'b1;
                     cmd.out_status = RSP_OK;
                     cmd.out_src    = SRC_ZERO;
                  end
               end else if (req_func > FN_UNIQUE) begin
                  // unused code: no result, no change
                  state_in = ST_IDLE;
               end else if (!stat.holds) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_last   = 1'b1;
                  cmd.out_status = RSP_EMPTY;
                  cmd.out_src    = SRC_NONE;
               end else begin
                  unique case (req_func)
                     FN_DEQ: begin
                        cmd.slot_rd   = 1'b1;
                        cmd.slot_addr = RA_HEAD;
                        cmd.deq       = 1'b1;
                        state_in      = ST_SINGLE;
                     end
                     FN_PEEK: begin
                        cmd.slot_rd   = 1'b1;
                        cmd.slot_addr = RA_HEAD;
                        state_in      = ST_SINGLE;
                     end
                     FN_LIST_FWD: begin
                        cmd.slot_rd   = 1'b1;
                        cmd.slot_addr = RA_HEAD;
                        cmd.cur_op    = CUR_HEAD;
                        state_in      = ST_LIST;
                     end
                     FN_LIST_REV: begin
                        cmd.slot_rd   = 1'b1;
                        cmd.slot_addr = RA_TAIL;
                        cmd.cur_op    = CUR_TAIL;
                        state_in      = ST_LIST;
                     end
                     FN_REVERSE: begin
                        cmd.cur_op = CUR_TAIL;
                        cmd.k_op   = K_ZERO;
                        state_in   = ST_R1_RD;
                     end
                     FN_UNIQUE: begin
                        cmd.slot_rd    = 1'b1;
                        cmd.slot_addr  = RA_HEAD;
                        cmd.cur_op     = CUR_HEAD;
                        cmd.seen_clear = 1'b1;
                        state_in       = ST_U_WORD;
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
            end
         end
         ST_SINGLE: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = RSP_OK;
               cmd.out_src    = SRC_SLOT;
               cmd.out_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = RSP_OK;
               cmd.out_src    = SRC_SLOT;
               cmd.out_last   = stat.at_end;
               if (stat.at_end) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.cur_op    = CUR_STEP;
                  cmd.slot_rd   = 1'b1;
                  cmd.slot_addr = RA_CUR_NEXT;
               end
            end
         end
         // first pass copies newest-first into scratch, second writes it back from slot 0
         ST_R1_RD: begin
            cmd.slot_rd   = 1'b1;
            cmd.slot_addr = RA_CURSOR;
            state_in      = ST_R1_WR;
         end
         ST_R1_WR: begin
            cmd.seen_wr = SW_SLOT;
            if (stat.at_end) begin
               cmd.k_op = K_ZERO;
               state_in = ST_R2_RD;
            end else begin
               cmd.cur_op = CUR_STEP;
               cmd.k_op   = K_STEP;
               state_in   = ST_R1_RD;
            end
         end
         ST_R2_RD: begin
            cmd.seen_rd   = 1'b1;
            cmd.seen_addr = SR_K;
            state_in      = ST_R2_WR;
         end
         ST_R2_WR: begin
            cmd.slot_wr_tmp = 1'b1;
            if (stat.k_at_span) begin
               cmd.rev_done = 1'b1;
               state_in     = ST_REV_DONE;
            end else begin
               cmd.k_op = K_STEP;
               state_in = ST_R2_RD;
            end
         end
         ST_REV_DONE: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = RSP_OK;
               cmd.out_src    = SRC_ZERO;
               cmd.out_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_U_WORD: begin
            cmd.word_ld = 1'b1;
            cmd.k_op    = K_ZERO;
            if (stat.seen_empty) begin
               state_in = ST_U_EMIT;
            end else begin
               cmd.seen_rd   = 1'b1;
               cmd.seen_addr = SR_ZERO;
               state_in      = ST_U_CMP;
            end
         end
         ST_U_CMP: begin
            if (stat.hit) begin
               if (stat.at_end) begin
                  state_in = ST_U_FINAL;
               end else begin
                  cmd.cur_op    = CUR_STEP;
                  cmd.slot_rd   = 1'b1;
                  cmd.slot_addr = RA_CUR_NEXT;
                  state_in      = ST_U_WORD;
               end
            end else if (stat.k_last_seen) begin
               state_in = ST_U_EMIT;
            end else begin
               cmd.k_op      = K_STEP;
               cmd.seen_rd   = 1'b1;
               cmd.seen_addr = SR_K_NEXT;
            end
         end
         // a new unique word releases the pending one, so the final result can carry last
         ST_U_EMIT: begin
            if (stat.seen_empty || stat.out_free) begin
               cmd.out_load   = !stat.seen_empty;
               cmd.out_status = RSP_OK;
               cmd.out_src    = SRC_PEND;
               cmd.seen_wr    = SW_APPEND;
               if (stat.at_end) begin
                  state_in = ST_U_FINAL;
               end else begin
                  cmd.cur_op    = CUR_STEP;
                  cmd.slot_rd   = 1'b1;
                  cmd.slot_addr = RA_CUR_NEXT;
                  state_in      = ST_U_WORD;
               end
            end
         end
         ST_U_FINAL: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = RSP_OK;
               cmd.out_src    = SRC_PEND;
               cmd.out_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/lqrd_datapath.sv =====
module lqrd_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lqrd_pkg::cmd_type                   cmd,
   input  logic signed [lqrd_pkg::WORD_W-1:0]  req_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [lqrd_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [lqrd_pkg::WORD_W-1:0]  rsp_data,
   output logic                                rsp_last,
   output lqrd_pkg::stat_type                  stat
);

   import lqrd_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   logic [AW-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic              holds_ff, holds_in;
   logic [CW-1:0]     seen_count_ff, seen_count_in;
   logic [AW-1:0]     cursor_ff, cursor_in, k_ff, k_in;
   logic              dir_ff, dir_in;
   logic [WORD_W-1:0] word_ff, pend_ff;
   logic              rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [WORD_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;

   logic [AW-1:0]     cur_next, k_next, enq_addr;
   logic              out_free;

   logic              slot_wr_en;
   logic [AW-1:0]     slot_wr_addr, slot_rd_addr;
   logic [WORD_W-1:0] slot_wr_data, slot_rdata;
   logic              seen_wr_en;
   logic [AW-1:0]     seen_wr_addr, seen_rd_addr;
   logic [WORD_W-1:0] seen_wr_data, seen_rdata;
   logic [WORD_W-1:0] out_word;

   assign cur_next = dir_ff ? cursor_ff - 1'b1 : cursor_ff + 1'b1;
   assign k_next   = k_ff + 1'b1;
   assign enq_addr = holds_ff ? tail_ff + 1'b1 : '0;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // slot store
   always_comb begin
      unique case (cmd.slot_addr)
         RA_HEAD:     slot_rd_addr = head_ff;
         RA_TAIL:     slot_rd_addr = tail_ff;
         RA_CURSOR:   slot_rd_addr = cursor_ff;
         RA_CUR_NEXT: slot_rd_addr = cur_next;
         default:     slot_rd_addr = head_ff;
      endcase
   end

   assign slot_wr_en   = cmd.enq || cmd.slot_wr_tmp;
   assign slot_wr_addr = cmd.enq ? enq_addr : k_ff;
   assign slot_wr_data = cmd.enq ? req_value : seen_rdata;

   lqrd_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_slots (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (cmd.slot_rd),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rdata)
   );

   // seen-value store, also scratch for the in-place reversal
   always_comb begin
      unique case (cmd.seen_addr)
         SR_ZERO:   seen_rd_addr = '0;
         SR_K:      seen_rd_addr = k_ff;
         SR_K_NEXT: seen_rd_addr = k_next;
         default:   seen_rd_addr = '0;
      endcase
   end

   assign seen_wr_en   = (cmd.seen_wr != SW_NONE);
   assign seen_wr_addr = (cmd.seen_wr == SW_SLOT) ? k_ff : seen_count_ff[AW-1:0];
   assign seen_wr_data = (cmd.seen_wr == SW_SLOT) ? slot_rdata : word_ff;

   lqrd_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_seen (
      .clock   (clock),
      .wr_en   (seen_wr_en),
      .wr_addr (seen_wr_addr),
      .wr_data (seen_wr_data),
      .rd_en   (cmd.seen_rd),
      .rd_addr (seen_rd_addr),
      .rd_data (seen_rdata)
   );

   // pointers and counters
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      holds_in      = holds_ff;
      seen_count_in = seen_count_ff;
      if (cmd.enq) begin
         if (!holds_ff) begin
            head_in = '0;
         end
         tail_in  = enq_addr;
         holds_in = 1'b1;
      end else if (cmd.deq) begin
         if (head_ff == tail_ff) begin
            head_in  = '0;
            tail_in  = '0;
            holds_in = 1'b0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end else if (cmd.rev_done) begin
         head_in = '0;
         tail_in = k_ff;
      end
      if (cmd.seen_clear) begin
         seen_count_in = '0;
      end else if (cmd.seen_wr == SW_APPEND) begin
         seen_count_in = seen_count_ff + 1'b1;
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      dir_in    = dir_ff;
      unique case (cmd.cur_op)
         CUR_HOLD: cursor_in = cursor_ff;
         CUR_HEAD: begin
            cursor_in = head_ff;
            dir_in    = 1'b0;
         end
         CUR_TAIL: begin
            cursor_in = tail_ff;
            dir_in    = 1'b1;
         end
         CUR_STEP: cursor_in = cur_next;
         default:  cursor_in = cursor_ff;
      endcase
      unique case (cmd.k_op)
         K_ZERO:  k_in = '0;
         K_STEP:  k_in = k_next;
         default: k_in = k_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.out_src)
         SRC_ZERO: out_word = '0;
         SRC_NONE: out_word = '1;
         SRC_SLOT: out_word = slot_rdata;
         SRC_PEND: out_word = pend_ff;
         default:  out_word = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         holds_ff      <= 1'b0;
         seen_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         holds_ff      <= holds_in;
         seen_count_ff <= seen_count_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      dir_ff    <= dir_in;
      k_ff      <= k_in;
      if (cmd.word_ld) begin
         word_ff <= slot_rdata;
      end
      if (cmd.seen_wr == SW_APPEND) begin
         pend_ff <= word_ff;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.out_status;
         rsp_data_ff   <= out_word;
         rsp_last_ff   <= cmd.out_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = $signed(rsp_data_ff);
   assign rsp_last   = rsp_last_ff;

   assign stat.holds       = holds_ff;
   assign stat.full        = (tail_ff == LAST_SLOT);
   assign stat.at_end      = dir_ff ? (cursor_ff == head_ff) : (cursor_ff == tail_ff);
   assign stat.k_at_span   = (k_ff == (tail_ff - head_ff));
   assign stat.k_last_seen = ((CW'(k_ff) + 1'b1) == seen_count_ff);
   assign stat.seen_empty  = (seen_count_ff == '0);
   assign stat.hit         = (seen_rdata == word_ff);
   assign stat.out_free    = out_free;

endmodule

// ===== sv/linear_queue_with_reverse_dedup_top.sv =====
// enqueue/overflow/empty: result next cycle, 1 per cycle unless stalled; unused code gives none
// dequeue and peek: the registered read of the slot memory, then the result register
// list forward or reverse of n entries: one memory read per result
// reverse in place: two copy passes through the scratch memory
// list unique: one scratch compare per cycle
// synchronous reset clears pointers, counters and control; memories are not cleared
module linear_queue_with_reverse_dedup_top #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lqrd_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [lqrd_pkg::WORD_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lqrd_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [lqrd_pkg::WORD_W-1:0]  rsp_data,
   output logic                                rsp_last
);

   import lqrd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lqrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   lqrd_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_value),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last),
      .stat       (stat)
   );

endmodule

// ===== sv/lqrd_checker.sv =====
`include "linear_queue_with_reverse_dedup_top_macros.svh"

module lqrd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [lqrd_pkg::STATUS_W-1:0]       rsp_status,
   input logic signed [lqrd_pkg::WORD_W-1:0]  rsp_data,
   input logic                                rsp_last
);

   import lqrd_pkg::*;

   `LQRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data) && $stable(rsp_status) && $stable(rsp_last), "stalled result changed")

   // overflow and empty carry the all-ones word and close the command
   `LQRD_ASSERT_NOW(a_err_word, clock, reset, rsp_valid && (rsp_status != RSP_OK), (rsp_data == '1) && rsp_last, "error result without -1 or last")

   // only listings give more than one result, and those are always ok
   `LQRD_ASSERT_NOW(a_mid_ok, clock, reset, rsp_valid && !rsp_last, rsp_status == RSP_OK, "non-final result with error status")

   // while a listing is still open no new command may be taken
   `LQRD_ASSERT_NOW(a_busy_list, clock, reset, rsp_valid && !rsp_stall && !rsp_last, req_stall, "command taken during open listing")

endmodule

bind linear_queue_with_reverse_dedup_top lqrd_checker u_checker (.*);
